### hw/rtl/jddm_pkg.sv
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types and constants of the differential drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 48;
    localparam int DUTY_BITS      = 12;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GEAR_DUTIES    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STICK_LIMITS   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GEAR_SELECT    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PID_ENABLE     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE_INVERT = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GYRO_SETPOINT  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PI_GAINS       = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PI_LIMITS      = 3'd7;

    localparam logic [1:0] DIR_NONE    = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    localparam logic [4:0] HOLD_FORWARD_BRAKE = 5'd25;
    localparam logic [4:0] HOLD_REVERSE_BRAKE = 5'd10;

    typedef struct packed {
        logic [7:0]         stick_vertical;
        logic [7:0]         stick_horizontal;
        logic               left_blocked;
        logic               right_blocked;
        logic signed [15:0] gyro_z;
    } in_word_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] left_forward_duty;
        logic [DUTY_BITS-1:0] left_back_duty;
        logic [DUTY_BITS-1:0] right_forward_duty;
        logic [DUTY_BITS-1:0] right_back_duty;
        logic [4:0]           hold_ms;
        logic                 last;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture input word, start steering map
        logic map_step;  // one quotient bit of the steering map
        logic pi_mul;    // form PI products
        logic pi_fin;    // sum, round, clamp, update integral
        logic emit;      // build result word
        logic emit_zero; // build the trailing zero word
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic changed;   // stick differs from previous sample
        logic map_done;
        logic use_pi;
        logic brake;     // a brake pulse precedes the zero word
    } dp_stat_t;

endpackage

### hw/rtl/jddm_datapath.sv
// ----------------------------------------------------------------------------
// jddm_datapath
// Steering map divider, PI loop arithmetic and result word assembly.
// ----------------------------------------------------------------------------
module jddm_datapath #(
    parameter int GEAR_COUNT = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  jddm_pkg::in_word_t     in_word,
    input  logic [47:0]            gear_duties,
    input  logic [47:0]            stick_limits,
    input  logic [1:0]             gear_select,
    input  logic                   pid_enable,
    input  logic                   reverse_invert,
    input  logic signed [15:0]     gyro_setpoint,
    input  logic [31:0]            pi_gains,
    input  logic [31:0]            pi_limits,
    input  jddm_pkg::dp_cmd_t      cmd,
    output jddm_pkg::dp_stat_t     stat,
    output jddm_pkg::out_word_t    res_word
);
    import jddm_pkg::*;

    localparam int GSEL_BITS = (GEAR_COUNT > 1) ? $clog2(GEAR_COUNT) : 1;
    localparam int NUM_BITS  = DUTY_BITS + 9;   // |x-a| * top
    localparam int QCNT_BITS = $clog2(NUM_BITS + 1);
    localparam logic [DUTY_BITS-1:0] DMAX = {DUTY_BITS{1'b1}};

    function automatic logic [DUTY_BITS-1:0] slot(input logic [47:0] gd, input int idx);
        if (idx * DUTY_BITS >= 48) return '0;
        return DUTY_BITS'((gd >> (idx * DUTY_BITS)) & 48'(DMAX));
    endfunction

    // Captured sample and state
    in_word_t                w_reg;
    logic [7:0]              prev_v_reg, prev_h_reg;
    logic [1:0]              dir_reg;
    logic signed [31:0]      integ_reg;
    logic [DUTY_BITS-1:0]    g_reg;
    // Divider
    logic [NUM_BITS-1:0]     num_reg;
    logic [8:0]              den_reg;
    logic [NUM_BITS-1:0]     quo_reg;
    logic [8:0]              rem_reg;
    logic [QCNT_BITS-1:0]    qcnt_reg;
    logic                    neg_reg;
    logic                    map_zero_reg;
    logic [DUTY_BITS-1:0]    cut_reg;
    // PI
    logic signed [31:0]      acc_reg;
    logic signed [35:0]      pterm_reg;
    logic signed [48:0]      iterm_reg;
    logic [DUTY_BITS-1:0]    pi_out_reg;
    // Result word
    logic [DUTY_BITS-1:0]    lf_duty, lb_duty, rf_duty, rb_duty;
    logic [4:0]              hold;
    logic                    fin;

    // Combinational helpers
    logic [7:0] vmin, vmax, hmin, hmax, dwl, upl;
    logic       fwd, rev, in_left, in_right;
    assign vmin = stick_limits[7:0];
    assign vmax = stick_limits[15:8];
    assign hmin = stick_limits[23:16];
    assign hmax = stick_limits[31:24];
    assign dwl  = stick_limits[39:32];
    assign upl  = stick_limits[47:40];
    assign fwd      = w_reg.stick_vertical > vmax;
    assign rev      = w_reg.stick_vertical < vmin;
    assign in_left  = w_reg.stick_horizontal < hmin;
    assign in_right = w_reg.stick_horizontal > hmax;

    // Map inputs for the loaded word
    logic signed [9:0] ma, mb, mx, dxa, dba;
    logic [GSEL_BITS-1:0] gidx;
    logic [DUTY_BITS-1:0] gsel;
    logic                 lin_left;
    always_comb
    begin
        // gear_select is two bits, so with GEAR_COUNT of 2 or more one subtract wraps it
        if (int'(gear_select) >= GEAR_COUNT)
            gidx = GSEL_BITS'(int'(gear_select) - GEAR_COUNT);
        else
            gidx = GSEL_BITS'(gear_select);
        gsel = slot(gear_duties, int'(gidx));
        mx   = 10'(in_word.stick_horizontal);
        lin_left  = (in_word.stick_horizontal < hmin) && !(in_word.stick_horizontal < dwl);
        if (lin_left)
        begin
            ma = 10'(hmin) - 10'sd1;
            mb = 10'(dwl);
        end
        else
        begin
            ma = 10'(hmax) + 10'sd1;
            mb = 10'(upl);
        end
        dxa = mx - ma;
        dba = mb - ma;
    end

    logic [NUM_BITS-1:0] num_mag;
    logic [8:0]          dxa_mag, dba_mag;
    always_comb
    begin
        dxa_mag = dxa[9] ? 9'(-dxa) : 9'(dxa);
        dba_mag = dba[9] ? 9'(-dba) : 9'(dba);
        num_mag = NUM_BITS'(dxa_mag) * NUM_BITS'(gsel);
    end

    // One restoring division step
    logic [9:0] rem_sh;
    logic       q_bit;
    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NUM_BITS-1]};
        q_bit  = rem_sh >= 10'(den_reg);
    end

    // Steering cut (truncating quotient, saturated)
    logic [DUTY_BITS-1:0] cut_now;
    always_comb
    begin
        if (map_zero_reg || neg_reg)
            cut_now = '0;
        else if (quo_reg > NUM_BITS'(DMAX))
            cut_now = DMAX;
        else
            cut_now = DUTY_BITS'(quo_reg);
    end

    logic [DUTY_BITS-1:0] cl, cr;
    always_comb
    begin
        cl = '0;
        cr = '0;
        if (in_left)
            cl = (w_reg.stick_horizontal < dwl) ? g_reg : cut_reg;
        else if (in_right)
            cr = (w_reg.stick_horizontal > upl) ? g_reg : cut_reg;
    end

    always_comb
    begin
        stat.changed  = (in_word.stick_vertical != prev_v_reg)
                     || (in_word.stick_horizontal != prev_h_reg);
        stat.map_done = (qcnt_reg == '0);
        stat.use_pi   = pid_enable && (cl == '0) && (cr == '0)
                     && ((fwd && !w_reg.left_blocked && !w_reg.right_blocked)
                         || (!fwd && rev));
        stat.brake    = !fwd && !rev && !in_left && !in_right && (dir_reg != DIR_NONE);
    end

    // PI combinational pieces
    logic signed [15:0] sp;
    logic signed [17:0] err_now;
    logic signed [33:0] acc_wide;
    logic signed [31:0] acc_sat;
    always_comb
    begin
        sp       = gyro_setpoint;
        err_now  = fwd ? (18'(sp) - 18'(w_reg.gyro_z)) : (-18'(sp) - 18'(w_reg.gyro_z));
        acc_wide = 34'(integ_reg) + 34'(err_now);
        if (acc_wide > 34'sd2147483647)
            acc_sat = 32'sh7fffffff;
        else if (acc_wide < -34'sd2147483648)
            acc_sat = 32'sh80000000;
        else
            acc_sat = 32'(acc_wide);
    end

    logic signed [49:0] sum;
    logic        [49:0] mag;
    logic signed [50:0] v;
    logic signed [15:0] plo, phi;
    logic [DUTY_BITS-1:0] pi_now;
    always_comb
    begin
        sum = 50'(pterm_reg) + 50'(iterm_reg);
        plo = pi_limits[15:0];
        phi = pi_limits[31:16];
        if (!sum[49])
        begin
            mag = (50'(sum) + 50'd128) >> 8;
            v   = 51'(mag);
        end
        else
        begin
            mag = (50'(-sum) + 50'd128) >> 8;
            v   = -51'(mag);
        end
        if (v > 51'(phi))
            v = 51'(phi);
        else if (v < 51'(plo))
            v = 51'(plo);
        if (v < 0)
            pi_now = '0;
        else if (v > 51'(DMAX))
            pi_now = DMAX;
        else
            pi_now = DUTY_BITS'(v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_v_reg <= '0;
            prev_h_reg <= '0;
            dir_reg    <= DIR_NONE;
            integ_reg  <= '0;
            qcnt_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_v_reg <= in_word.stick_vertical;
                prev_h_reg <= in_word.stick_horizontal;
                qcnt_reg   <= QCNT_BITS'(NUM_BITS);
            end
            else if (cmd.map_step && qcnt_reg != '0)
                qcnt_reg <= qcnt_reg - 1'b1;
            if (cmd.pi_fin)
                integ_reg <= acc_reg;
            if (cmd.emit)
            begin
                if (fwd)
                    dir_reg <= DIR_FORWARD;
                else if (rev)
                    dir_reg <= DIR_REVERSE;
                else
                    dir_reg <= DIR_NONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg        <= in_word;
            g_reg        <= gsel;
            num_reg      <= num_mag;
            den_reg      <= dba_mag;
            quo_reg      <= '0;
            rem_reg      <= '0;
            neg_reg      <= (dxa[9] ^ dba[9]) && (dxa != 0);
            map_zero_reg <= (dba == 0);
        end
        else if (cmd.map_step && qcnt_reg != '0)
        begin
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[NUM_BITS-2:0], q_bit};
            rem_reg <= q_bit ? 9'(rem_sh - 10'(den_reg)) : rem_sh[8:0];
        end
        if (cmd.map_step && qcnt_reg == '0)
            cut_reg <= cut_now;
        if (cmd.pi_mul)
        begin
            acc_reg   <= acc_sat;
            pterm_reg <= 36'($signed({1'b0, pi_gains[15:0]}) * err_now);
            iterm_reg <= 49'($signed({1'b0, pi_gains[31:16]}) * acc_sat);
        end
        if (cmd.pi_fin)
            pi_out_reg <= pi_now;
    end

    // Result word assembly
    logic [DUTY_BITS-1:0] sl, sr, tl, tr;
    always_comb
    begin
        tl = (g_reg > cl) ? g_reg - cl : '0;
        tr = (g_reg > cr) ? g_reg - cr : '0;
        sl = tl;
        sr = tr;
        if (rev && !fwd && reverse_invert)
        begin
            sl = (g_reg > cr) ? g_reg - cr : '0;
            sr = (g_reg > cl) ? g_reg - cl : '0;
        end
        if (stat.use_pi)
            sr = pi_out_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            lf_duty <= '0;
            lb_duty <= '0;
            rf_duty <= '0;
            rb_duty <= '0;
            hold    <= '0;
            fin     <= 1'b1;
            if (fwd)
            begin
                if (!w_reg.left_blocked && !w_reg.right_blocked)
                begin
                    lf_duty <= sl;
                    rf_duty <= sr;
                end
                else if (w_reg.left_blocked && !w_reg.right_blocked)
                begin
                    lf_duty <= slot(gear_duties, 3);
                    rb_duty <= slot(gear_duties, 2);
                end
                else if (w_reg.right_blocked && !w_reg.left_blocked)
                begin
                    lb_duty <= slot(gear_duties, 2);
                    rf_duty <= slot(gear_duties, 3);
                end
            end
            else if (rev)
            begin
                lb_duty <= sl;
                rb_duty <= sr;
            end
            else if (in_right)
            begin
                lf_duty <= g_reg;
                rb_duty <= g_reg;
            end
            else if (in_left)
            begin
                lb_duty <= g_reg;
                rf_duty <= g_reg;
            end
            else if (dir_reg == DIR_FORWARD)
            begin
                lb_duty <= g_reg;
                rb_duty <= g_reg;
                hold    <= HOLD_FORWARD_BRAKE;
                fin     <= 1'b0;
            end
            else if (dir_reg == DIR_REVERSE)
            begin
                lf_duty <= g_reg;
                rf_duty <= g_reg;
                hold    <= HOLD_REVERSE_BRAKE;
                fin     <= 1'b0;
            end
        end
        else if (cmd.emit_zero)
        begin
            lf_duty <= '0;
            lb_duty <= '0;
            rf_duty <= '0;
            rb_duty <= '0;
            hold    <= '0;
            fin     <= 1'b1;
        end
    end

    assign res_word = {lf_duty, lb_duty, rf_duty, rb_duty, hold, fin};

endmodule

### hw/rtl/jddm_ctrl.sv
// ----------------------------------------------------------------------------
// jddm_ctrl
// Sequencer: accept, divide, PI, emit one or two result words; a word with an unchanged stick is dropped.
// ----------------------------------------------------------------------------
module jddm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  jddm_pkg::dp_stat_t stat,
    output jddm_pkg::dp_cmd_t  cmd
);
    import jddm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_OUT1 = 3'd5;
    localparam logic [2:0] S_OUT2 = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       take;

    assign in_stall  = (state_reg != S_IDLE);
    assign take      = in_valid && (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT1) || (state_reg == S_OUT2);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
                if (take && stat.changed)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MAP;
                end
            S_MAP:
            begin
                cmd.map_step = 1'b1;
                if (stat.map_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.pi_mul = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.use_pi)
                    cmd.pi_fin = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = stat.brake ? S_OUT1 : S_OUT2;
            end
            S_OUT1:
                if (!out_stall)
                begin
                    cmd.emit_zero = 1'b1;
                    state_next    = S_OUT2;
                end
            S_OUT2:
                if (!out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hw/rtl/joystick_differential_drive_mixer.sv
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer
// Stick to H-bridge duty mixer with steering map, gyro PI trim and brake.
// ----------------------------------------------------------------------------
// One input word is taken at a time. A word whose stick equals the previous
// sample is dropped with no result. Otherwise the word passes a bit-serial
// restoring divider for the steering map, then the PI product and finish
// steps, before its result is offered; a new word is not taken until every
// result word has been delivered. A brake after forward or reverse yields
// two result words, the pulse and a zero word.
// Configuration writes are taken in any cycle but belong to idle periods.
module joystick_differential_drive_mixer #(
    parameter int GEAR_COUNT = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  jddm_pkg::in_word_t     in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output jddm_pkg::out_word_t    out_data,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [47:0]            cfg_data
);
    import jddm_pkg::*;

    logic [47:0]        gear_duties_reg, stick_limits_reg;
    logic [1:0]         gear_select_reg;
    logic               pid_enable_reg, reverse_invert_reg;
    logic signed [15:0] gyro_setpoint_reg;
    logic [31:0]        pi_gains_reg, pi_limits_reg;

    // Register file: write only, one register per index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_duties_reg    <= '0;
            stick_limits_reg   <= '0;
            gear_select_reg    <= '0;
            pid_enable_reg     <= 1'b0;
            reverse_invert_reg <= 1'b0;
            gyro_setpoint_reg  <= '0;
            pi_gains_reg       <= '0;
            pi_limits_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GEAR_DUTIES:    gear_duties_reg    <= cfg_data;
                REG_STICK_LIMITS:   stick_limits_reg   <= cfg_data;
                REG_GEAR_SELECT:    gear_select_reg    <= cfg_data[1:0];
                REG_PID_ENABLE:     pid_enable_reg     <= cfg_data[0];
                REG_REVERSE_INVERT: reverse_invert_reg <= cfg_data[0];
                REG_GYRO_SETPOINT:  gyro_setpoint_reg  <= cfg_data[15:0];
                REG_PI_GAINS:       pi_gains_reg       <= cfg_data[31:0];
                REG_PI_LIMITS:      pi_limits_reg      <= cfg_data[31:0];
                default:            ;
            endcase
        end
    end

    dp_cmd_t  cmd;
    dp_stat_t stat;

    jddm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    jddm_datapath #(
        .GEAR_COUNT (GEAR_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_word        (in_data),
        .gear_duties    (gear_duties_reg),
        .stick_limits   (stick_limits_reg),
        .gear_select    (gear_select_reg),
        .pid_enable     (pid_enable_reg),
        .reverse_invert (reverse_invert_reg),
        .gyro_setpoint  (gyro_setpoint_reg),
        .pi_gains       (pi_gains_reg),
        .pi_limits      (pi_limits_reg),
        .cmd            (cmd),
        .stat           (stat),
        .res_word       (out_data)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the differential drive mixer: a directed table of
// stick words, then randomized phases under changing register settings, each
// result word compared against a behavioral duty predictor.
// ----------------------------------------------------------------------------
module tb;
    import jddm_pkg::*;

    localparam int DB = DUTY_BITS;
    localparam int SETTLE_CYCLES = DB + 30;   // covers a dropped word in flight
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t r;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    in_word_t      in_data;
    logic          out_valid;
    logic          out_stall;
    out_word_t     out_data;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [47:0]   cfg_data;

    joystick_differential_drive_mixer #(.GEAR_COUNT(4)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mirror of the register file
    logic [47:0]        m_gears;
    logic [47:0]        m_limits;
    logic [1:0]         m_gear_sel;
    logic               m_pid_on;
    logic               m_rev_swap;
    logic signed [15:0] m_setpoint;
    logic [31:0]        m_gains;
    logic [31:0]        m_pi_lim;

    // Mirror of the block state
    logic [7:0] m_prev_v;
    logic [7:0] m_prev_h;
    logic [1:0] m_dir;
    int         m_integral;

    out_word_t  duty_expect[$];
    int         mismatches;
    int         idle_cycles;
    bit         stall_enable;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip_duty(longint v);
        if (v < 0)
            return 0;
        if (v > (1 << DB) - 1)
            return (1 << DB) - 1;
        return v;
    endfunction

    function automatic longint gear_slot(int idx);
        return longint'(m_gears[idx*DB +: DB]);
    endfunction

    function automatic longint limit_byte(int idx);
        return longint'(m_limits[8*idx +: 8]);
    endfunction

    function automatic longint map_cut(longint x, longint a, longint b, longint top);
        if (a == b)
            return 0;
        return clip_duty((x - a) * top / (b - a));
    endfunction

    // Gyro PI trim: updates the integral, returns the right side duty
    function automatic longint pi_trim(longint sp, longint pv);
        longint err, acc, kp, ki, lo, hi, sum, v;
        err = sp - pv;
        acc = longint'(m_integral) + err;
        kp = longint'(m_gains[15:0]);
        ki = longint'(m_gains[31:16]);
        lo = longint'($signed(m_pi_lim[15:0]));
        hi = longint'($signed(m_pi_lim[31:16]));
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        m_integral = int'(acc);
        sum = kp * err + ki * acc;
        if (sum >= 0)
            v = (sum + 128) / 256;
        else
            v = -((-sum + 128) / 256);
        if (v > hi)
            v = hi;
        else if (v < lo)
            v = lo;
        return clip_duty(v);
    endfunction

    function automatic out_word_t mk_word(longint lf, longint lb, longint rf, longint rb,
                                          int hold, bit fin);
        out_word_t d;
        d.left_forward_duty = DB'(clip_duty(lf));
        d.left_back_duty = DB'(clip_duty(lb));
        d.right_forward_duty = DB'(clip_duty(rf));
        d.right_back_duty = DB'(clip_duty(rb));
        d.hold_ms = 5'(hold);
        d.last = fin;
        return d;
    endfunction

    // Predict the result words of one stick word; returns their count
    function automatic int mix_stick(in_word_t w, output out_word_t res[2]);
        longint lv, rh, g, cl, cr, sl, sr, vmin, vmax, hmin, hmax, dwl, upl;
        int n;
        lv = longint'(w.stick_vertical);
        rh = longint'(w.stick_horizontal);
        vmin = limit_byte(0);
        vmax = limit_byte(1);
        hmin = limit_byte(2);
        hmax = limit_byte(3);
        dwl = limit_byte(4);
        upl = limit_byte(5);
        cl = 0;
        cr = 0;
        n = 1;
        if (w.stick_vertical == m_prev_v && w.stick_horizontal == m_prev_h)
            return 0;
        m_prev_v = w.stick_vertical;
        m_prev_h = w.stick_horizontal;
        g = gear_slot(int'(m_gear_sel));
        if (rh < hmin)
            cl = (rh < dwl) ? g : map_cut(rh, hmin - 1, dwl, g);
        else if (rh > hmax)
            cr = (rh > upl) ? g : map_cut(rh, hmax + 1, upl, g);

        if (lv > vmax)
        begin
            m_dir = DIR_FORWARD;
            sl = clip_duty(g - cl);
            sr = clip_duty(g - cr);
            if (!w.left_blocked && !w.right_blocked)
            begin
                if (m_pid_on && cl == 0 && cr == 0)
                    sr = pi_trim(longint'(m_setpoint), longint'(w.gyro_z));
                res[0] = mk_word(sl, 0, sr, 0, 0, 1'b1);
            end
            else if (w.left_blocked && !w.right_blocked)
                res[0] = mk_word(gear_slot(3), 0, 0, gear_slot(2), 0, 1'b1);
            else if (w.right_blocked && !w.left_blocked)
                res[0] = mk_word(0, gear_slot(2), gear_slot(3), 0, 0, 1'b1);
            else
                res[0] = mk_word(0, 0, 0, 0, 0, 1'b1);
        end
        else if (lv < vmin)
        begin
            m_dir = DIR_REVERSE;
            sl = clip_duty(g - (m_rev_swap ? cr : cl));
            sr = clip_duty(g - (m_rev_swap ? cl : cr));
            if (m_pid_on && cl == 0 && cr == 0)
                sr = pi_trim(-longint'(m_setpoint), longint'(w.gyro_z));
            res[0] = mk_word(0, sl, 0, sr, 0, 1'b1);
        end
        else if (rh > hmax)
        begin
            m_dir = DIR_NONE;
            res[0] = mk_word(g, 0, 0, g, 0, 1'b1);
        end
        else if (rh < hmin)
        begin
            m_dir = DIR_NONE;
            res[0] = mk_word(0, g, g, 0, 0, 1'b1);
        end
        else
        begin
            // Centered stick: counter-drive pulse first if we were moving
            if (m_dir == DIR_FORWARD)
            begin
                res[0] = mk_word(0, g, 0, g, int'(HOLD_FORWARD_BRAKE), 1'b0);
                n = 2;
            end
            else if (m_dir == DIR_REVERSE)
            begin
                res[0] = mk_word(g, 0, g, 0, int'(HOLD_REVERSE_BRAKE), 1'b0);
                n = 2;
            end
            m_dir = DIR_NONE;
            res[n-1] = mk_word(0, 0, 0, 0, 0, 1'b1);
        end
        return n;
    endfunction

    // Hold off until the block has drained, then write one register
    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        wait (duty_expect.size() == 0);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GEAR_DUTIES:    m_gears = val;
            REG_STICK_LIMITS:   m_limits = val;
            REG_GEAR_SELECT:    m_gear_sel = val[1:0];
            REG_PID_ENABLE:     m_pid_on = val[0];
            REG_REVERSE_INVERT: m_rev_swap = val[0];
            REG_GYRO_SETPOINT:  m_setpoint = val[15:0];
            REG_PI_GAINS:       m_gains = val[31:0];
            default:            m_pi_lim = val[31:0];
        endcase
    endtask

    task automatic settle();
        wait (duty_expect.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_all(logic [47:0] gears, logic [47:0] limits, logic [1:0] gsel,
                             logic pid, logic swap, logic [15:0] sp,
                             logic [31:0] gains, logic [31:0] plim);
        settle();
        write_reg(REG_GEAR_DUTIES, gears);
        write_reg(REG_STICK_LIMITS, limits);
        write_reg(REG_GEAR_SELECT, 48'(gsel));
        write_reg(REG_PID_ENABLE, 48'(pid));
        write_reg(REG_REVERSE_INVERT, 48'(swap));
        write_reg(REG_GYRO_SETPOINT, 48'(sp));
        write_reg(REG_PI_GAINS, 48'(gains));
        write_reg(REG_PI_LIMITS, 48'(plim));
    endtask

    // Queue the expected words, then hold the word until it is taken
    task automatic send_word(in_word_t w, bit typed, out_word_t typed_res, bit gaps);
        out_word_t res[2];
        int n, gap, pick;
        n = mix_stick(w, res);
        if (typed)
            res[0] = typed_res;
        for (int k = 0; k < n; k++)
            duty_expect.push_back(res[k]);
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pick = $urandom_range(0, 99);
        gap = !gaps || pick < 60 ? 0 : (pick < 92 ? $urandom_range(1, 3)
                                                  : $urandom_range(5, 30));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic in_word_t stick(int v, int h, bit lb, bit rb, int gz);
        in_word_t w;
        w.stick_vertical = 8'(v);
        w.stick_horizontal = 8'(h);
        w.left_blocked = lb;
        w.right_blocked = rb;
        w.gyro_z = 16'(gz);
        return w;
    endfunction

    function automatic stim_row_t row(in_word_t w, bit typed, out_word_t r);
        stim_row_t s;
        s.w = w;
        s.typed = typed;
        s.r = r;
        return s;
    endfunction

    // Random stick word biased toward the centre and toward high vertical values
    function automatic in_word_t random_stick(in_word_t prev);
        in_word_t w;
        int pick;
        pick = $urandom_range(0, 99);
        w = prev;
        if (pick < 8)
            return w;   // unchanged stick, dropped by the block
        pick = $urandom_range(0, 9);
        w.stick_vertical = pick < 3 ? 8'(128) :
                           (pick < 6 ? 8'($urandom_range(160, 255))
                                     : 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 9);
        w.stick_horizontal = pick < 4 ? 8'(128) : 8'($urandom_range(0, 255));
        w.left_blocked = ($urandom_range(0, 99) < 15);
        w.right_blocked = ($urandom_range(0, 99) < 15);
        w.gyro_z = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
        return w;
    endfunction

    // Output side: random stall with long and short stretches
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            int len, pick;
            pick = $urandom_range(0, 99);
            len = pick < 85 ? $urandom_range(1, 4) : $urandom_range(10, 40);
            out_stall <= stall_enable && ($urandom_range(0, 2) == 0);
            repeat (len) @(posedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            out_word_t got, want;
            got = out_data;
            if (duty_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %p", got);
            end
            else
            begin
                want = duty_expect.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result mismatch exp %p got %p", want, got);
                end
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t  table_rows[$];
        out_word_t  none;
        in_word_t   w;
        logic [47:0] gears_a, limits_a;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        stall_enable = 1'b0;
        none = '0;
        m_gears = '0;
        m_limits = '0;
        m_gear_sel = '0;
        m_pid_on = 1'b0;
        m_rev_swap = 1'b0;
        m_setpoint = '0;
        m_gains = '0;
        m_pi_lim = '0;
        m_prev_v = '0;
        m_prev_h = '0;
        m_dir = DIR_NONE;
        m_integral = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: stick equal to reset state is dropped, any other
        // vertical counts as forward with zero gear duty
        send_word(stick(0, 0, 0, 0, 0), 1'b0, none, 1'b0);
        send_word(stick(5, 0, 0, 0, 0), 1'b1, mk_word(0, 0, 0, 0, 0, 1'b1), 1'b0);
        send_word(stick(255, 255, 1, 1, -32768), 1'b0, none, 1'b0);
        in_valid <= 1'b0;

        gears_a = {12'd4000, 12'd3000, 12'd2000, 12'd1000};
        limits_a = {8'd235, 8'd20, 8'd156, 8'd100, 8'd156, 8'd100};
        write_all(gears_a, limits_a, 2'd0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0);

        table_rows.push_back(row(stick(255, 128, 0, 0, 0), 1, mk_word(1000, 0, 1000, 0, 0, 1)));
        table_rows.push_back(row(stick(128, 128, 0, 0, 0), 1,
                                 mk_word(0, 1000, 0, 1000, 25, 0)));
        table_rows.push_back(row(stick(128, 128, 1, 1, 7), 0, none));
        table_rows.push_back(row(stick(0, 128, 0, 0, 0), 1, mk_word(0, 1000, 0, 1000, 0, 1)));
        table_rows.push_back(row(stick(128, 129, 0, 0, 0), 1,
                                 mk_word(1000, 0, 1000, 0, 10, 0)));
        table_rows.push_back(row(stick(128, 255, 0, 0, 0), 1, mk_word(1000, 0, 0, 1000, 0, 1)));
        table_rows.push_back(row(stick(128, 0, 0, 0, 0), 1, mk_word(0, 1000, 1000, 0, 0, 1)));
        table_rows.push_back(row(stick(255, 0, 0, 0, 0), 1, mk_word(0, 0, 1000, 0, 0, 1)));
        table_rows.push_back(row(stick(255, 255, 1, 0, 0), 1, mk_word(4000, 0, 0, 3000, 0, 1)));
        table_rows.push_back(row(stick(254, 255, 0, 1, 0), 1, mk_word(0, 3000, 4000, 0, 0, 1)));
        table_rows.push_back(row(stick(253, 255, 1, 1, 0), 1, mk_word(0, 0, 0, 0, 0, 1)));
        table_rows.push_back(row(stick(0, 255, 0, 0, 0), 1, mk_word(0, 1000, 0, 0, 0, 1)));
        table_rows.push_back(row(stick(0, 60, 0, 0, 0), 0, none));
        table_rows.push_back(row(stick(255, 200, 0, 0, -32768), 0, none));
        table_rows.push_back(row(stick(255, 99, 0, 0, 32767), 0, none));
        table_rows.push_back(row(stick(1, 157, 0, 0, 0), 0, none));
        table_rows.push_back(row(stick(128, 100, 0, 0, 0), 0, none));
        table_rows.push_back(row(stick(128, 156, 0, 0, 0), 0, none));
        foreach (table_rows[i])
            send_word(table_rows[i].w, table_rows[i].typed, table_rows[i].r, 1'b1);
        in_valid <= 1'b0;

        // Random phases, first two at extreme settings
        w = stick(128, 128, 0, 0, 0);
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [47:0] limits;
            if (ph == 0)
                write_all('1, '1, 2'd3, 1'b1, 1'b1, 16'h7FFF, '1, 32'h7FFF_8000);
            else if (ph == 1)
                write_all({12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF},
                          {8'd255, 8'd0, 8'd128, 8'd127, 8'd128, 8'd127},
                          2'd2, 1'b1, 1'b0, 16'h8000, 32'h0100_0100, 32'h8000_7FFF);
            else
            begin
                limits = {8'($urandom_range(170, 255)), 8'($urandom_range(0, 90)),
                          8'($urandom_range(128, 160)), 8'($urandom_range(96, 127)),
                          8'($urandom_range(128, 160)), 8'($urandom_range(96, 127))};
                if (ph == 7)
                    limits[47:32] = {8'(limits[31:24] + 1), 8'(limits[23:16] - 1)};
                write_all({12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)},
                          limits, 2'($urandom), 1'($urandom), 1'($urandom),
                          16'($urandom_range(0, 600) - 300),
                          {16'($urandom_range(0, 64)), 16'($urandom_range(0, 1024))},
                          {16'($urandom_range(0, 4095)), 16'(-$urandom_range(0, 500))});
            end
            // Alternate between free-running and stalled stretches
            stall_enable = (ph % 3 != 2);
            for (int i = 0; i < 175; i++)
            begin
                w = random_stick(w);
                send_word(w, 1'b0, none, ph % 3 != 2);
            end
            in_valid <= 1'b0;
        end

        wait (duty_expect.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && duty_expect.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
